### hdl/jse_pkg.sv
// Shared types, character codes and lookup functions for the JSON string escape encoder.
`timescale 1ns / 1ps

package jse_pkg;

    // Character codes
    localparam logic [7:0] QUOTE_CHAR     = 8'h22;
    localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
    localparam logic [7:0] SLASH_CHAR     = 8'h2F;
    localparam logic [7:0] CONTROL_LIMIT  = 8'h20;
    localparam logic [7:0] DELETE_CHAR    = 8'h7F;
    localparam logic [7:0] LETTER_U       = 8'h75;
    localparam logic [7:0] DIGIT_ZERO     = 8'h30;
    localparam logic [7:0] NO_ESCAPE      = 8'h00;

    // Longest expansion of one transaction: quote + six-byte escape + quote
    localparam int MAX_BYTES  = 8;
    localparam int BODY_BYTES = 6;

    typedef logic [3:0] t_count;

    // Expanded byte sequence of one transaction, byte 0 goes out first
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        t_count                    count;
    } t_seq;

    // Short escape letter for a byte, NO_ESCAPE if it has none
    function automatic logic [7:0] short_escape(input logic [7:0] b);
        logic [7:0] esc;
        case (b)
            QUOTE_CHAR:     esc = QUOTE_CHAR;
            BACKSLASH_CHAR: esc = BACKSLASH_CHAR;
            SLASH_CHAR:     esc = SLASH_CHAR;
            8'h08:          esc = 8'h62; // b
            8'h0C:          esc = 8'h66; // f
            8'h0A:          esc = 8'h6E; // n
            8'h0D:          esc = 8'h72; // r
            8'h09:          esc = 8'h74; // t
            default:        esc = NO_ESCAPE;
        endcase
        return esc;
    endfunction

    // Lowercase hex digit for a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10) begin
            d = DIGIT_ZERO + {4'h0, nib};
        end else begin
            d = 8'h57 + {4'h0, nib}; // 'a' - 10
        end
        return d;
    endfunction

endpackage

### hdl/json_string_escape_encoder_top.sv
// Top level of the JSON string escape encoder.
`timescale 1ns / 1ps

// A transaction (one source byte with optional opening and closing quotes) is taken at a clock
// edge with start high and busy low. It expands into 0 to 8 bytes of JSON text, which come out
// one per cycle on o_out_byte, each marked by o_strobe for exactly one cycle; o_run_last flags
// the final byte of the transaction. The receiver cannot stall, so every strobed byte must be
// taken when shown. The first byte passes through the sequence buffer and then the output
// register. A transaction holds busy while more than one of its bytes is still to leave the
// sequence buffer, so the input rate is set by the output port at one byte per cycle: plain
// bytes flow at one transaction per cycle; a longer run lets the next in with its last byte.

module json_string_escape_encoder_top
    import jse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_source_byte,
    input  logic       i_byte_present,
    input  logic       i_open_quote,
    input  logic       i_close_quote,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_strobe
);

    t_seq seq;
    logic load;

    assign load = start & ~busy;

    jse_expand u_expand (
        .i_source_byte (i_source_byte),
        .i_byte_present(i_byte_present),
        .i_open_quote  (i_open_quote),
        .i_close_quote (i_close_quote),
        .o_seq         (seq)
    );

    jse_serializer u_serializer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_seq     (seq),
        .o_busy    (busy),
        .o_out_byte(o_out_byte),
        .o_run_last(o_run_last),
        .o_strobe  (o_strobe)
    );

endmodule

### hdl/jse_expand.sv
// Combinational expansion of one input transaction into its escaped byte sequence.
`timescale 1ns / 1ps

module jse_expand
    import jse_pkg::*;
(
    input  logic [7:0] i_source_byte,
    input  logic       i_byte_present,
    input  logic       i_open_quote,
    input  logic       i_close_quote,
    output t_seq       o_seq
);

    logic [BODY_BYTES-1:0][7:0] body;
    t_count                     body_len;
    logic [7:0]                 esc;
    t_count                     j;

    assign esc = short_escape(i_source_byte);

    // Escaped form of the source byte alone
    always_comb begin
        body     = '0;
        body_len = 4'd0;
        if (i_byte_present) begin
            if (esc != NO_ESCAPE) begin
                body[0]  = BACKSLASH_CHAR;
                body[1]  = esc;
                body_len = 4'd2;
            end else if (i_source_byte < CONTROL_LIMIT || i_source_byte == DELETE_CHAR) begin
                body[0]  = BACKSLASH_CHAR;
                body[1]  = LETTER_U;
                body[2]  = DIGIT_ZERO;
                body[3]  = DIGIT_ZERO;
                body[4]  = hex_digit(i_source_byte[7:4]);
                body[5]  = hex_digit(i_source_byte[3:0]);
                body_len = 4'd6;
            end else begin
                body[0]  = i_source_byte;
                body_len = 4'd1;
            end
        end
    end

    // Place optional quotes around the body, one independent mux per position
    always_comb begin
        o_seq.bytes = '0;
        j           = '0;
        for (int i = 0; i < MAX_BYTES; i++) begin
            j = 4'(i) - {3'b000, i_open_quote};
            if (i_open_quote && i == 0) begin
                o_seq.bytes[i] = QUOTE_CHAR;
            end else if (j < body_len) begin
                o_seq.bytes[i] = body[j[2:0]];
            end else if (j == body_len && i_close_quote) begin
                o_seq.bytes[i] = QUOTE_CHAR;
            end else begin
                o_seq.bytes[i] = 8'h00;
            end
        end
        o_seq.count = {3'b000, i_open_quote} + body_len + {3'b000, i_close_quote};
    end

endmodule

### hdl/jse_serializer.sv
// Sequence buffer and output register: sends one escaped byte per cycle.
`timescale 1ns / 1ps

module jse_serializer
    import jse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_seq       i_seq,
    output logic       o_busy,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_strobe
);

    logic [MAX_BYTES-1:0][7:0] r_buf, n_buf;
    t_count                    r_cnt, n_cnt;
    logic [7:0]                r_out_byte, n_out_byte;
    logic                      r_run_last, n_run_last;
    logic                      r_strobe, n_strobe;

    // Busy while the buffer still holds more than the byte leaving this cycle
    assign o_busy = (r_cnt > 4'd1);

    // Pop the head byte into the output register, refill on a new transaction
    always_comb begin
        n_buf      = {8'h00, r_buf[MAX_BYTES-1:1]};
        n_cnt      = r_cnt;
        n_out_byte = r_buf[0];
        n_run_last = (r_cnt == 4'd1);
        n_strobe   = (r_cnt != 4'd0);
        if (r_cnt != 4'd0) begin
            n_cnt = r_cnt - 4'd1;
        end
        if (i_load) begin
            n_buf = i_seq.bytes;
            n_cnt = i_seq.count;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_buf      <= n_buf;
        r_out_byte <= n_out_byte;
        r_run_last <= n_run_last;
    end

    assign o_out_byte = r_out_byte;
    assign o_run_last = r_run_last & r_strobe;
    assign o_strobe   = r_strobe;

endmodule

### hdl/jse_checker.sv
// Port-level assertions for the JSON string escape encoder, bound to the top level.
`timescale 1ns / 1ps

module jse_checker
    import jse_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [7:0] i_source_byte,
    input logic       i_byte_present,
    input logic       i_open_quote,
    input logic       i_close_quote,
    input logic [7:0] o_out_byte,
    input logic       o_run_last,
    input logic       o_strobe
);

    logic plain_single;

    // A lone printable byte that needs no escape
    assign plain_single = start && !busy && i_byte_present && !i_open_quote && !i_close_quote
                          && i_source_byte >= CONTROL_LIMIT && i_source_byte < DELETE_CHAR
                          && i_source_byte != QUOTE_CHAR && i_source_byte != BACKSLASH_CHAR
                          && i_source_byte != SLASH_CHAR;

    // Reset leaves nothing pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !busy))
        else $error("output or busy active after reset");

    // Busy means more bytes of the current run are still due
    a_busy_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_strobe && !o_run_last))
        else $error("busy without a continuing run");

    // A run has no gaps until its last byte
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_run_last) |=> o_strobe)
        else $error("gap inside an output run");

    // A plain byte passes through the sequence buffer and output register as a one-byte run
    a_plain_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        plain_single |-> ##2 (o_strobe && o_run_last && o_out_byte == $past(i_source_byte, 2)))
        else $error("plain byte not passed through");

endmodule

bind json_string_escape_encoder_top jse_checker u_jse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_source_byte (i_source_byte),
    .i_byte_present(i_byte_present),
    .i_open_quote  (i_open_quote),
    .i_close_quote (i_close_quote),
    .o_out_byte    (o_out_byte),
    .o_run_last    (o_run_last),
    .o_strobe      (o_strobe)
);

### bench/tb_top.sv
// Self-checking bench for the JSON string escape encoder: directed table, then random strings.
`timescale 1ns / 1ps

module tb_top;
    import jse_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int RESET_CYCLES    = 9;
    localparam int ITEMS_PER_PHASE = 25;
    localparam int DRAIN_CYCLES    = 8;
    localparam int NUM_PHASES      = 3;

    // One byte of escaped text, as the block should present it
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_json_byte;

    // One stimulus row; typed rows carry their expected text inline
    typedef struct packed {
        logic [7:0]  src;
        logic        pres;
        logic        oq;
        logic        cq;
        logic        typed;
        logic [3:0]  n;
        logic [63:0] text;
    } t_stim_row;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       start          = 1'b0;
    logic [7:0] i_source_byte  = 8'h00;
    logic       i_byte_present = 1'b0;
    logic       i_open_quote   = 1'b0;
    logic       i_close_quote  = 1'b0;
    wire        busy;
    wire  [7:0] o_out_byte;
    wire        o_run_last;
    wire        o_strobe;

    t_json_byte pending_bytes [$];
    int         mismatches  = 0;
    int         cycle_count = 0;
    int         idle_pct    = 0;
    int         idle_by_phase [NUM_PHASES] = '{0, 62, 14};

    json_string_escape_encoder_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_source_byte  (i_source_byte),
        .i_byte_present (i_byte_present),
        .i_open_quote   (i_open_quote),
        .i_close_quote  (i_close_quote),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_strobe       (o_strobe)
    );

    // Clock
    always #4 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH %s: got %02h want %02h (cycle %0d)", what, got, want, cycle_count);
        mismatches++;
    endtask

    function automatic logic [7:0] nibble_to_hex(input logic [3:0] nib);
        if (nib < 4'd10)
            return DIGIT_ZERO + 8'(nib);
        else
            return "a" + 8'(nib) - 8'd10;
    endfunction

    // Expected escaped text of one transaction, appended to the pending store
    task automatic queue_escaped(input logic [7:0] b, input logic pres, input logic oq,
                                 input logic cq);
        logic [7:0] seq [$];
        logic [7:0] letter;
        t_json_byte jb;
        if (oq)
            seq.push_back(QUOTE_CHAR);
        if (pres) begin
            case (b)
                QUOTE_CHAR:     letter = QUOTE_CHAR;
                BACKSLASH_CHAR: letter = BACKSLASH_CHAR;
                SLASH_CHAR:     letter = SLASH_CHAR;
                8'h08:          letter = "b";
                8'h0C:          letter = "f";
                8'h0A:          letter = "n";
                8'h0D:          letter = "r";
                8'h09:          letter = "t";
                default:        letter = NO_ESCAPE;
            endcase
            if (letter != NO_ESCAPE) begin
                seq.push_back(BACKSLASH_CHAR);
                seq.push_back(letter);
            end else if (b < CONTROL_LIMIT || b == DELETE_CHAR) begin
                // long form \u00XX
                seq.push_back(BACKSLASH_CHAR);
                seq.push_back(LETTER_U);
                seq.push_back(DIGIT_ZERO);
                seq.push_back(DIGIT_ZERO);
                seq.push_back(nibble_to_hex(b[7:4]));
                seq.push_back(nibble_to_hex(b[3:0]));
            end else begin
                seq.push_back(b);
            end
        end
        if (cq)
            seq.push_back(QUOTE_CHAR);
        foreach (seq[k]) begin
            jb.data = seq[k];
            jb.last = (k == seq.size() - 1);
            pending_bytes.push_back(jb);
        end
    endtask

    function automatic t_stim_row mk_row(input logic [7:0] src, input logic pres,
                                         input logic oq, input logic cq, input logic typed,
                                         input logic [3:0] n, input logic [63:0] text);
        t_stim_row r;
        r.src   = src;
        r.pres  = pres;
        r.oq    = oq;
        r.cq    = cq;
        r.typed = typed;
        r.n     = n;
        r.text  = text;
        return r;
    endfunction

    // Source byte biased toward control codes and escaped characters
    function automatic logic [7:0] pick_byte();
        logic [7:0] specials [4] = '{QUOTE_CHAR, BACKSLASH_CHAR, SLASH_CHAR, DELETE_CHAR};
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 31));
            1:       return specials[$urandom_range(0, 3)];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Drive one transaction, with optional idle cycles first; returns after acceptance
    task automatic send_item(input t_stim_row r);
        t_json_byte jb;
        while ($urandom_range(0, 99) < idle_pct) begin
            start          <= 1'b0;
            i_source_byte  <= 8'($urandom_range(0, 255));
            i_byte_present <= 1'($urandom_range(0, 1));
            i_open_quote   <= 1'($urandom_range(0, 1));
            i_close_quote  <= 1'($urandom_range(0, 1));
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_source_byte  <= r.src;
        i_byte_present <= r.pres;
        i_open_quote   <= r.oq;
        i_close_quote  <= r.cq;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (r.typed) begin
            for (int k = 0; k < r.n; k++) begin
                jb.data = r.text[8 * (r.n - 1 - k) +: 8];
                jb.last = (k == r.n - 1);
                pending_bytes.push_back(jb);
            end
        end else begin
            queue_escaped(r.src, r.pres, r.oq, r.cq);
        end
    endtask

    // Output checker: every strobed byte against the oldest expectation
    always @(posedge i_clk) begin : check_output
        t_json_byte want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch("unexpected byte", o_out_byte, 8'h00);
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_byte !== want.data)
                    report_mismatch("out_byte", o_out_byte, want.data);
                if (o_run_last !== want.last)
                    report_mismatch("run_last", 8'(o_run_last), 8'(want.last));
            end
        end
    end

    // Main sequence
    initial begin : main
        t_stim_row  dir_rows [$];
        int         counted;
        int         len;
        logic       pres;
        logic       oq;
        logic       cq;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every escape class, quote-only cases
        dir_rows.push_back(mk_row(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0, 64'h0));
        dir_rows.push_back(mk_row(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 4'd2, "\"\""));
        dir_rows.push_back(mk_row(8'hFF, 1'b0, 1'b1, 1'b0, 1'b1, 4'd1, "\""));
        dir_rows.push_back(mk_row(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 4'd1, "\""));
        dir_rows.push_back(mk_row(8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 4'd6, "\\u0000"));
        dir_rows.push_back(mk_row(8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, 4'd1, 64'hFF));
        dir_rows.push_back(mk_row("A",   1'b1, 1'b1, 1'b1, 1'b1, 4'd3, "\"A\""));
        dir_rows.push_back(mk_row(QUOTE_CHAR, 1'b1, 1'b0, 1'b0, 1'b1, 4'd2, "\\\""));
        dir_rows.push_back(mk_row(BACKSLASH_CHAR, 1'b1, 1'b0, 1'b0, 1'b1, 4'd2, "\\\\"));
        dir_rows.push_back(mk_row(SLASH_CHAR, 1'b1, 1'b0, 1'b0, 1'b1, 4'd2, "\\/"));
        dir_rows.push_back(mk_row(8'h08, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0));
        dir_rows.push_back(mk_row(8'h0C, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0));
        dir_rows.push_back(mk_row(8'h0A, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0));
        dir_rows.push_back(mk_row(8'h0D, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0));
        dir_rows.push_back(mk_row(8'h09, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0));
        dir_rows.push_back(mk_row(8'h1F, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0));
        dir_rows.push_back(mk_row(8'h10, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0));
        dir_rows.push_back(mk_row(8'h1A, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0));
        dir_rows.push_back(mk_row(DELETE_CHAR, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0));
        dir_rows.push_back(mk_row(CONTROL_LIMIT, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0));
        dir_rows.push_back(mk_row(8'h7E, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0));
        dir_rows.push_back(mk_row(8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0));
        // longest expansion: quote, \u00XX, quote
        dir_rows.push_back(mk_row(8'h1F, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0, 64'h0));
        dir_rows.push_back(mk_row(DELETE_CHAR, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0, 64'h0));
        // absent byte with no quotes: nothing comes out
        dir_rows.push_back(mk_row(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0));
        foreach (dir_rows[i])
            send_item(dir_rows[i]);

        // Random: mostly quoted strings, some loose flag combinations
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            idle_pct = idle_by_phase[phase];
            counted  = 0;
            while (counted < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 75) begin
                    len = $urandom_range(0, 6);
                    if (len == 0) begin
                        send_item(mk_row(pick_byte(), 1'b0, 1'b1, 1'b1, 1'b0, 4'd0, 64'h0));
                        counted++;
                    end else begin
                        for (int k = 0; k < len; k++) begin
                            send_item(mk_row(pick_byte(), 1'b1, k == 0, k == len - 1,
                                             1'b0, 4'd0, 64'h0));
                        end
                        counted += len;
                    end
                end else begin
                    pres = 1'($urandom_range(0, 1));
                    oq   = 1'($urandom_range(0, 1));
                    cq   = 1'($urandom_range(0, 1));
                    send_item(mk_row(pick_byte(), pres, oq, cq, 1'b0, 4'd0, 64'h0));
                    if (pres || oq || cq)
                        counted++;
                end
            end
        end
        start <= 1'b0;

        // Drain outstanding bytes, then watch for strays
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
